FILE: sv/complex_arithmetic_unit_core_defines.svh
// Assertion macros shared by the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CAU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CAU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cau_pkg.sv
package cau_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int DIV_SHIFT   = 32 - FRAC_BITS;
    localparam int QUOT_BITS   = 32;
    localparam int ROOT_BITS   = 32;
    localparam int UNIT_LAT    = QUOT_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MAG = 3'd4;

    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_MUL = 3'd2;
    localparam logic [2:0] KIND_DIV = 3'd3;
    localparam logic [2:0] KIND_MAG = 3'd4;
    localparam logic [2:0] KIND_NOP = 3'd5;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_SAT  = 2'd1;
    localparam logic [1:0] STAT_DIV0 = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
        logic               b_zero;
    } cau_item_t;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } cau_sat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        b_zero;
        logic        neg_re;
        logic        neg_im;
        logic [31:0] pre_re;
        logic [31:0] pre_im;
        logic        pre_sat;
    } cau_side_t;

    // Clamp a sign and magnitude pair to the signed 32-bit range
    function automatic cau_sat_t sat_mag(input logic neg, input logic [63:0] mag);
        cau_sat_t r;
        r.sat = 1'b0;
        r.val = mag[31:0];
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                r.sat = 1'b1;
                r.val = 32'h8000_0000;
            end else begin
                r.val = 32'd0 - mag[31:0];
            end
        end else if (mag > 64'h0000_0000_7FFF_FFFF) begin
            r.sat = 1'b1;
            r.val = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

FILE: sv/complex_arithmetic_unit_core.sv
// Throughput: one transaction per cycle while the result side does not stall, set by
// the pipelined dividers and square-root unit, which take a new operand every cycle
// in which the pipeline advances.
// Reset: aresetn is synchronous and active low; it empties the queue and clears
// every valid bit, so no result is presented until new input is accepted.
`include "complex_arithmetic_unit_core_defines.svh"

module complex_arithmetic_unit_core import cau_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_opcode,
    input  logic signed [31:0] s_a_re,
    input  logic signed [31:0] s_a_im,
    input  logic signed [31:0] s_b_re,
    input  logic signed [31:0] s_b_im,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_res_re,
    output logic signed [31:0] m_res_im,
    output logic [1:0]         m_status
);

    logic      q_valid;
    logic      q_ready;
    cau_item_t q_item;

    // Accept and classify
    cau_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .s_a_re   (s_a_re),
        .s_a_im   (s_a_im),
        .s_b_re   (s_b_re),
        .s_b_im   (s_b_im),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    // Compute and deliver
    cau_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res_re (m_res_re),
        .m_res_im (m_res_im),
        .m_status (m_status)
    );

    `CAU_ASSERT_NEXT(a_queue_fills, aclk, aresetn, s_valid && s_ready, q_valid,
        "accepted transaction not queued")
    `CAU_ASSERT_NEXT(a_queue_holds, aclk, aresetn, q_valid && !q_ready, q_valid,
        "queued transaction lost while stalled")
    `CAU_ASSERT_NOW(a_div0_zero, aclk, aresetn, m_valid && (m_status == STAT_DIV0),
        (m_res_re == 32'sd0) && (m_res_im == 32'sd0),
        "division by zero gave nonzero result")
    `CAU_ASSERT_NOW(a_sat_bound, aclk, aresetn, m_valid && (m_status == STAT_SAT),
        (m_res_re == 32'sh7FFF_FFFF) || (m_res_re == 32'sh8000_0000) ||
        (m_res_im == 32'sh7FFF_FFFF) || (m_res_im == 32'sh8000_0000),
        "saturation status without a clamped part")

endmodule

FILE: sv/cau_front.sv
module cau_front import cau_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_opcode,
    input  logic signed [31:0] s_a_re,
    input  logic signed [31:0] s_a_im,
    input  logic signed [31:0] s_b_re,
    input  logic signed [31:0] s_b_im,
    output logic               q_valid,
    input  logic               q_ready,
    output cau_item_t          q_item
);

    cau_item_t           queue_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    cau_item_t           item_in;
    logic                push;
    logic                pop;

    // Classify the incoming transaction
    always_comb begin
        unique case (s_opcode)
            OP_ADD:  item_in.kind = KIND_ADD;
            OP_SUB:  item_in.kind = KIND_SUB;
            OP_MUL:  item_in.kind = KIND_MUL;
            OP_DIV:  item_in.kind = KIND_DIV;
            OP_MAG:  item_in.kind = KIND_MAG;
            default: item_in.kind = KIND_NOP;
        endcase
        item_in.a_re   = s_a_re;
        item_in.a_im   = s_a_im;
        item_in.b_re   = s_b_re;
        item_in.b_im   = s_b_im;
        item_in.b_zero = (s_b_re == 32'sd0) && (s_b_im == 32'sd0);
    end

    assign s_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = queue_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // Store queued transactions
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= item_in;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: sv/cau_div.sv
module cau_div import cau_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [63:0]          num,
    input  logic [63:0]          den,
    output logic [QUOT_BITS-1:0] quot,
    output logic                 over
);

    logic [63:0]          rem_reg  [QUOT_BITS];
    logic [63:0]          den_reg  [QUOT_BITS];
    logic [31:0]          feed_reg [QUOT_BITS];
    logic [QUOT_BITS-1:0] quot_reg [QUOT_BITS+1];
    logic                 over_reg [QUOT_BITS+1];

    // Detect a quotient of 2^32 or more and load the top of the dividend
    always_ff @(posedge aclk) begin
        if (en) begin
            over_reg[0] <= {{DIV_SHIFT{1'b0}}, num} >= {den, {DIV_SHIFT{1'b0}}};
            rem_reg[0]  <= num >> DIV_SHIFT;
            feed_reg[0] <= {num[DIV_SHIFT-1:0], {FRAC_BITS{1'b0}}};
            den_reg[0]  <= den;
            quot_reg[0] <= '0;
        end
    end

    // One quotient bit per stage
    for (genvar i = 1; i <= QUOT_BITS; i++) begin : g_stage
        logic [64:0] shifted;
        logic        ge;
        assign shifted = {rem_reg[i-1], feed_reg[i-1][31]};
        assign ge      = shifted >= {1'b0, den_reg[i-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                quot_reg[i] <= {quot_reg[i-1][QUOT_BITS-2:0], ge};
                over_reg[i] <= over_reg[i-1];
            end
        end
        if (i < QUOT_BITS) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i]  <= ge ? 64'(shifted - {1'b0, den_reg[i-1]}) : shifted[63:0];
                    den_reg[i]  <= den_reg[i-1];
                    feed_reg[i] <= {feed_reg[i-1][30:0], 1'b0};
                end
            end
        end
    end

    assign quot = quot_reg[QUOT_BITS];
    assign over = over_reg[QUOT_BITS];

endmodule

FILE: sv/cau_sqrt.sv
module cau_sqrt import cau_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [63:0]          rad,
    output logic [ROOT_BITS-1:0] root
);

    logic [33:0]          rem_reg  [ROOT_BITS];
    logic [63:0]          rad_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg [ROOT_BITS+1];

    // Load the radicand
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= '0;
            rad_reg[0]  <= rad;
            root_reg[0] <= '0;
        end
    end

    // One root bit per stage, two radicand bits consumed
    for (genvar i = 1; i <= ROOT_BITS; i++) begin : g_stage
        logic [35:0] cur;
        logic [35:0] trial;
        logic        ge;
        assign cur   = {rem_reg[i-1], rad_reg[i-1][63:62]};
        assign trial = {2'b00, root_reg[i-1], 2'b01};
        assign ge    = cur >= trial;
        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[i] <= {root_reg[i-1][ROOT_BITS-2:0], ge};
            end
        end
        if (i < ROOT_BITS) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= ge ? 34'(cur - trial) : cur[33:0];
                    rad_reg[i] <= {rad_reg[i-1][61:0], 2'b00};
                end
            end
        end
    end

    assign root = root_reg[ROOT_BITS];

endmodule

FILE: sv/cau_back.sv
module cau_back import cau_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  cau_item_t          q_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_res_re,
    output logic signed [31:0] m_res_im,
    output logic [1:0]         m_status
);

    logic en;

    logic      p0_valid_reg;
    cau_item_t p0_item_reg;

    logic               p1_valid_reg;
    cau_item_t          p1_item_reg;
    logic signed [63:0] p1_rr_reg, p1_ii_reg, p1_ir_reg, p1_ri_reg;
    logic signed [63:0] p1_sq0_reg, p1_sq1_reg;
    logic signed [31:0] sq0_op, sq1_op;

    logic               p2_valid_reg;
    logic [2:0]         p2_kind_reg;
    logic               p2_bzero_reg;
    logic signed [64:0] p2_sre_reg, p2_sim_reg;
    logic [63:0]        p2_den_reg;
    logic signed [64:0] sre_next, sim_next;

    logic        p3_valid_reg;
    logic [2:0]  p3_kind_reg;
    logic        p3_bzero_reg;
    logic        p3_nre_reg, p3_nim_reg;
    logic [63:0] p3_mre_reg, p3_mim_reg;
    logic [63:0] p3_den_reg;
    logic signed [64:0] neg_sre, neg_sim;

    logic                 side_valid_reg [UNIT_LAT];
    cau_side_t            side_reg       [UNIT_LAT];
    cau_side_t            side_in;
    cau_sat_t             fmt_re, fmt_im;
    logic [QUOT_BITS-1:0] quot_re, quot_im;
    logic                 over_re, over_im;
    logic [ROOT_BITS-1:0] root;

    cau_side_t          last;
    cau_sat_t           fin_re, fin_im;
    logic signed [31:0] res_re_next, res_im_next;
    logic [1:0]         status_next;

    logic               m_valid_reg;
    logic signed [31:0] m_res_re_reg, m_res_im_reg;
    logic [1:0]         m_status_reg;

    // Advance the whole back pipeline unless the result register is held
    assign en      = !m_valid_reg || m_ready;
    assign q_ready = en;

    // Take a transaction from the queue
    always_ff @(posedge aclk) begin
        if (en) begin
            p0_item_reg <= q_item;
        end
    end

    // Form the products; squares serve the divisor or the magnitude
    assign sq0_op = (p0_item_reg.kind == KIND_MAG) ? p0_item_reg.a_re : p0_item_reg.b_re;
    assign sq1_op = (p0_item_reg.kind == KIND_MAG) ? p0_item_reg.a_im : p0_item_reg.b_im;

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_item_reg <= p0_item_reg;
            p1_rr_reg   <= p0_item_reg.a_re * p0_item_reg.b_re;
            p1_ii_reg   <= p0_item_reg.a_im * p0_item_reg.b_im;
            p1_ir_reg   <= p0_item_reg.a_im * p0_item_reg.b_re;
            p1_ri_reg   <= p0_item_reg.a_re * p0_item_reg.b_im;
            p1_sq0_reg  <= sq0_op * sq0_op;
            p1_sq1_reg  <= sq1_op * sq1_op;
        end
    end

    // Combine into exact signed sums
    always_comb begin
        case (p1_item_reg.kind)
            KIND_ADD: begin
                sre_next = 65'(p1_item_reg.a_re) + 65'(p1_item_reg.b_re);
                sim_next = 65'(p1_item_reg.a_im) + 65'(p1_item_reg.b_im);
            end
            KIND_SUB: begin
                sre_next = 65'(p1_item_reg.a_re) - 65'(p1_item_reg.b_re);
                sim_next = 65'(p1_item_reg.a_im) - 65'(p1_item_reg.b_im);
            end
            KIND_MUL: begin
                sre_next = 65'(p1_rr_reg) - 65'(p1_ii_reg);
                sim_next = 65'(p1_ir_reg) + 65'(p1_ri_reg);
            end
            KIND_DIV: begin
                sre_next = 65'(p1_rr_reg) + 65'(p1_ii_reg);
                sim_next = 65'(p1_ir_reg) - 65'(p1_ri_reg);
            end
            default: begin
                sre_next = '0;
                sim_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_kind_reg  <= p1_item_reg.kind;
            p2_bzero_reg <= p1_item_reg.b_zero;
            p2_sre_reg   <= sre_next;
            p2_sim_reg   <= sim_next;
            p2_den_reg   <= 64'(p1_sq0_reg) + 64'(p1_sq1_reg);
        end
    end

    // Split into sign and magnitude
    assign neg_sre = -p2_sre_reg;
    assign neg_sim = -p2_sim_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_kind_reg  <= p2_kind_reg;
            p3_bzero_reg <= p2_bzero_reg;
            p3_nre_reg   <= p2_sre_reg[64];
            p3_nim_reg   <= p2_sim_reg[64];
            p3_mre_reg   <= p2_sre_reg[64] ? neg_sre[63:0] : p2_sre_reg[63:0];
            p3_mim_reg   <= p2_sim_reg[64] ? neg_sim[63:0] : p2_sim_reg[63:0];
            p3_den_reg   <= p2_den_reg;
        end
    end

    // Long-latency units
    cau_div u_div_re (
        .aclk (aclk),
        .en   (en),
        .num  (p3_mre_reg),
        .den  (p3_den_reg),
        .quot (quot_re),
        .over (over_re)
    );

    cau_div u_div_im (
        .aclk (aclk),
        .en   (en),
        .num  (p3_mim_reg),
        .den  (p3_den_reg),
        .quot (quot_im),
        .over (over_im)
    );

    cau_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (p3_den_reg),
        .root (root)
    );

    // Format add, subtract and multiply results alongside the units
    assign fmt_re = sat_mag(p3_nre_reg,
        (p3_kind_reg == KIND_MUL) ? (p3_mre_reg >> FRAC_BITS) : p3_mre_reg);
    assign fmt_im = sat_mag(p3_nim_reg,
        (p3_kind_reg == KIND_MUL) ? (p3_mim_reg >> FRAC_BITS) : p3_mim_reg);

    always_comb begin
        side_in.kind    = p3_kind_reg;
        side_in.b_zero  = p3_bzero_reg;
        side_in.neg_re  = p3_nre_reg;
        side_in.neg_im  = p3_nim_reg;
        side_in.pre_re  = fmt_re.val;
        side_in.pre_im  = fmt_im.val;
        side_in.pre_sat = fmt_re.sat || fmt_im.sat;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int i = 1; i < UNIT_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Track valid transactions through every stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            for (int i = 0; i < UNIT_LAT; i++) begin
                side_valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            p0_valid_reg      <= q_valid;
            p1_valid_reg      <= p0_valid_reg;
            p2_valid_reg      <= p1_valid_reg;
            p3_valid_reg      <= p2_valid_reg;
            side_valid_reg[0] <= p3_valid_reg;
            for (int i = 1; i < UNIT_LAT; i++) begin
                side_valid_reg[i] <= side_valid_reg[i-1];
            end
        end
    end

    // Select the final result
    assign last   = side_reg[UNIT_LAT-1];
    assign fin_re = sat_mag(last.neg_re, over_re ? 64'h1_0000_0000 : {32'd0, quot_re});
    assign fin_im = sat_mag(last.neg_im, over_im ? 64'h1_0000_0000 : {32'd0, quot_im});

    always_comb begin
        res_re_next = '0;
        res_im_next = '0;
        status_next = STAT_OK;
        case (last.kind) inside
            KIND_ADD, KIND_SUB, KIND_MUL: begin
                res_re_next = last.pre_re;
                res_im_next = last.pre_im;
                status_next = last.pre_sat ? STAT_SAT : STAT_OK;
            end
            KIND_DIV: begin
                if (last.b_zero) begin
                    status_next = STAT_DIV0;
                end else begin
                    res_re_next = fin_re.val;
                    res_im_next = fin_im.val;
                    status_next = (fin_re.sat || fin_im.sat) ? STAT_SAT : STAT_OK;
                end
            end
            KIND_MAG: begin
                res_re_next = root[ROOT_BITS-1] ? 32'sh7FFF_FFFF : root;
                status_next = root[ROOT_BITS-1] ? STAT_SAT : STAT_OK;
            end
            default: begin
                status_next = STAT_OK;
            end
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= side_valid_reg[UNIT_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_res_re_reg <= res_re_next;
            m_res_im_reg <= res_im_next;
            m_status_reg <= status_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_res_re = m_res_re_reg;
    assign m_res_im = m_res_im_reg;
    assign m_status = m_status_reg;

endmodule
